// ----- rtl/core/utf16_to_utf32_decoder_core_macros.svh -----
// ----------------------------------------------------------------------------
// utf16_to_utf32_decoder_core_macros
// Assertion macros of the decoder core; empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef UTF16_TO_UTF32_DECODER_CORE_MACROS_SVH
`define UTF16_TO_UTF32_DECODER_CORE_MACROS_SVH

`ifndef SYNTHESIS

`define U16DEC_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("u16dec assertion failed");

`define U16DEC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("u16dec assertion failed");

`else

`define U16DEC_ASSERT_SAME(label, clk, rst, ante, cons)

`define U16DEC_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ----- rtl/core/u16dec_pkg.sv -----
// ----------------------------------------------------------------------------
// u16dec_pkg
// Types and constants of the UTF-16 / Latin-1 to UTF-32 decoder core.
// ----------------------------------------------------------------------------
package u16dec_pkg;

   localparam int unsigned POSITION_WIDTH_DEFAULT = 16;
   localparam int unsigned UNIT_WIDTH             = 16;
   localparam int unsigned BYTE_WIDTH             = 8;
   localparam int unsigned CODE_POINT_WIDTH       = 21;
   localparam int unsigned ERROR_KIND_WIDTH       = 3;
   localparam int unsigned SURR_BITS              = 10;
   localparam int unsigned CSR_INDEX_WIDTH        = 2;
   localparam int unsigned CSR_DATA_WIDTH         = 1;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SURROGATE_DECODE = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BYTE_SOURCE      = 2'd1;

   localparam logic [UNIT_WIDTH-1:0] UNIT_BOM         = 16'hFEFF;
   localparam logic [UNIT_WIDTH-1:0] UNIT_BOM_SWAPPED = 16'hFFFE;
   localparam logic [UNIT_WIDTH-1:0] HIGH_SURR_FIRST  = 16'hD800;
   localparam logic [UNIT_WIDTH-1:0] LOW_SURR_FIRST   = 16'hDC00;
   localparam logic [UNIT_WIDTH-1:0] LOW_SURR_LAST    = 16'hDFFF;

   localparam logic [CODE_POINT_WIDTH-1:0] SUPP_PLANE_BASE = 21'h10000;

   typedef enum logic [ERROR_KIND_WIDTH-1:0] {
      ERR_NONE           = 3'd0,
      ERR_BOM            = 3'd1,
      ERR_LONE_LOW       = 3'd2,
      ERR_END_AFTER_HIGH = 3'd3,
      ERR_HIGH_NO_LOW    = 3'd4
   } error_kind_type;

   typedef struct packed {
      logic surrogate_decode;
      logic byte_source;
   } cfg_type;

   typedef struct packed {
      logic [CODE_POINT_WIDTH-1:0] code_point;
      error_kind_type              error_kind;
      logic                        result_last;
   } result_type;

endpackage

// ----- rtl/core/u16dec_req_if.sv -----
// ----------------------------------------------------------------------------
// u16dec_req_if
// Input channel: one code unit per transfer.
// ----------------------------------------------------------------------------
interface u16dec_req_if;
   import u16dec_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [UNIT_WIDTH-1:0] code_unit;
   logic                  unit_last;

   modport source (output valid, output code_unit, output unit_last, input ready);
   modport sink   (input valid, input code_unit, input unit_last, output ready);
endinterface

// ----- rtl/core/u16dec_rsp_if.sv -----
// ----------------------------------------------------------------------------
// u16dec_rsp_if
// Result channel: one code point or error report per transfer.
// ----------------------------------------------------------------------------
interface u16dec_rsp_if #(
   parameter int unsigned POSITION_WIDTH = u16dec_pkg::POSITION_WIDTH_DEFAULT
);
   import u16dec_pkg::*;

   logic                        valid;
   logic                        ready;
   logic [CODE_POINT_WIDTH-1:0] code_point;
   logic [ERROR_KIND_WIDTH-1:0] error_kind;
   logic [POSITION_WIDTH-1:0]   error_position;
   logic                        result_last;

   modport source (output valid, output code_point, output error_kind,
                   output error_position, output result_last, input ready);
   modport sink   (input valid, input code_point, input error_kind,
                   input error_position, input result_last, output ready);
endinterface

// ----- rtl/core/u16dec_csr_if.sv -----
// ----------------------------------------------------------------------------
// u16dec_csr_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface u16dec_csr_if;
   import u16dec_pkg::*;

   logic                       valid;
   logic                       ready;
   logic [CSR_INDEX_WIDTH-1:0] index;
   logic [CSR_DATA_WIDTH-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/core/u16dec_csr.sv -----
// ----------------------------------------------------------------------------
// u16dec_csr
// Configuration registers: surrogate decoding enable and byte source select.
// ----------------------------------------------------------------------------
module u16dec_csr (
   input  logic                clock,
   input  logic                reset,
   u16dec_csr_if.sink          csr_bus,
   output u16dec_pkg::cfg_type cfg
);
   import u16dec_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;
   logic    write;

   assign csr_bus.ready = !reset;
   assign write         = csr_bus.valid;

   always_comb begin
      cfg_in = cfg_ff;
      if (write) begin
         case (csr_bus.index)
            CSR_SURROGATE_DECODE: cfg_in.surrogate_decode = csr_bus.data[0];
            CSR_BYTE_SOURCE:      cfg_in.byte_source      = csr_bus.data[0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.surrogate_decode <= 1'b1;
         cfg_ff.byte_source      <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;
endmodule

// ----- rtl/core/u16dec_decode.sv -----
// ----------------------------------------------------------------------------
// u16dec_decode
// Per-unit decode and string state: pending high surrogate, index, discard.
// ----------------------------------------------------------------------------
`include "utf16_to_utf32_decoder_core_macros.svh"

module u16dec_decode #(
   parameter int unsigned POSITION_WIDTH = u16dec_pkg::POSITION_WIDTH_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  u16dec_pkg::cfg_type                    cfg,
   input  logic [u16dec_pkg::UNIT_WIDTH-1:0]      code_unit,
   input  logic                                   unit_last,
   input  logic                                   step,
   output logic                                   produce,
   output u16dec_pkg::result_type                 result,
   output logic [POSITION_WIDTH-1:0]              error_position
);
   import u16dec_pkg::*;

   localparam logic [POSITION_WIDTH-1:0] POS_MAX = '1;

   logic                      high_pending_ff, high_pending_in;
   logic [SURR_BITS-1:0]      high_bits_ff, high_bits_in;
   logic [POSITION_WIDTH-1:0] unit_index_ff, unit_index_in;
   logic                      discarding_ff, discarding_in;

   logic                        is_bom, is_high, is_low;
   logic                        emit, fail, hold;
   error_kind_type              kind;
   logic [CODE_POINT_WIDTH-1:0] cp;
   logic [POSITION_WIDTH-1:0]   index_adv;

   assign is_bom  = (code_unit == UNIT_BOM) || (code_unit == UNIT_BOM_SWAPPED);
   assign is_high = (code_unit >= HIGH_SURR_FIRST) && (code_unit < LOW_SURR_FIRST);
   assign is_low  = (code_unit >= LOW_SURR_FIRST) && (code_unit <= LOW_SURR_LAST);
   assign index_adv = (unit_index_ff == POS_MAX) ? unit_index_ff
                                                 : unit_index_ff + POSITION_WIDTH'(1);

   always_comb begin
      emit = 1'b0;
      fail = 1'b0;
      hold = 1'b0;
      kind = ERR_NONE;
      cp   = '0;
      if (discarding_ff) begin
         emit = 1'b0;
      end else if (cfg.byte_source || !cfg.surrogate_decode) begin
         emit = 1'b1;
         cp   = cfg.byte_source
              ? {{(CODE_POINT_WIDTH-BYTE_WIDTH){1'b0}}, code_unit[BYTE_WIDTH-1:0]}
              : {{(CODE_POINT_WIDTH-UNIT_WIDTH){1'b0}}, code_unit};
      end else if (high_pending_ff) begin
         if (!is_low) begin
            fail = 1'b1;
            kind = ERR_HIGH_NO_LOW;
         end else begin
            emit = 1'b1;
            cp   = {1'b0, high_bits_ff, code_unit[SURR_BITS-1:0]} + SUPP_PLANE_BASE;
         end
      end else if (is_bom) begin
         fail = 1'b1;
         kind = ERR_BOM;
      end else if (is_high) begin
         if (unit_last) begin
            fail = 1'b1;
            kind = ERR_END_AFTER_HIGH;
         end else begin
            hold = 1'b1;
         end
      end else if (is_low) begin
         fail = 1'b1;
         kind = ERR_LONE_LOW;
      end else begin
         emit = 1'b1;
         cp   = {{(CODE_POINT_WIDTH-UNIT_WIDTH){1'b0}}, code_unit};
      end
   end

   assign produce            = emit || fail;
   assign result.code_point  = fail ? '0 : cp;
   assign result.error_kind  = kind;
   assign result.result_last = fail || unit_last;
   assign error_position     = fail ? unit_index_ff : '0;

   always_comb begin
      if (unit_last) begin
         unit_index_in   = '0;
         high_pending_in = 1'b0;
         high_bits_in    = '0;
         discarding_in   = 1'b0;
      end else begin
         unit_index_in   = index_adv;
         high_pending_in = hold;
         high_bits_in    = hold ? code_unit[SURR_BITS-1:0] : '0;
         discarding_in   = discarding_ff || fail;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         high_pending_ff <= 1'b0;
         high_bits_ff    <= '0;
         unit_index_ff   <= '0;
         discarding_ff   <= 1'b0;
      end else if (step) begin
         high_pending_ff <= high_pending_in;
         high_bits_ff    <= high_bits_in;
         unit_index_ff   <= unit_index_in;
         discarding_ff   <= discarding_in;
      end
   end

   `U16DEC_ASSERT_SAME(a_error_shape, clock, reset, produce && (kind != ERR_NONE), (result.code_point == '0) && result.result_last)
   `U16DEC_ASSERT_SAME(a_discard_silent, clock, reset, discarding_ff, !produce)
   `U16DEC_ASSERT_NEXT(a_string_end_clears, clock, reset, step && unit_last, (unit_index_ff == '0) && !high_pending_ff && !discarding_ff)
   `U16DEC_ASSERT_NEXT(a_high_held, clock, reset, step && hold, high_pending_ff && (high_bits_ff == $past(code_unit[SURR_BITS-1:0])))
endmodule

// ----- rtl/core/u16dec_out_reg.sv -----
// ----------------------------------------------------------------------------
// u16dec_out_reg
// Result register driving the result channel.
// ----------------------------------------------------------------------------
module u16dec_out_reg #(
   parameter int unsigned POSITION_WIDTH = u16dec_pkg::POSITION_WIDTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          load,
   input  u16dec_pkg::result_type        result,
   input  logic [POSITION_WIDTH-1:0]     error_position,
   output logic                          out_free,
   u16dec_rsp_if.source                  rsp_bus
);
   import u16dec_pkg::*;

   logic                      valid_ff;
   result_type                result_ff;
   logic [POSITION_WIDTH-1:0] position_ff;

   assign out_free = !valid_ff || rsp_bus.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff   <= result;
         position_ff <= error_position;
      end
   end

   assign rsp_bus.valid          = valid_ff;
   assign rsp_bus.code_point     = result_ff.code_point;
   assign rsp_bus.error_kind     = result_ff.error_kind;
   assign rsp_bus.error_position = position_ff;
   assign rsp_bus.result_last    = result_ff.result_last;
endmodule

// ----- rtl/core/utf16_to_utf32_decoder_core.sv -----
// ----------------------------------------------------------------------------
// utf16_to_utf32_decoder_core
// UTF-16 / Latin-1 to UTF-32 decoder with surrogate pair checking.
// ----------------------------------------------------------------------------
// Usage:
//   req_bus carries one code unit per transfer; unit_last marks string end.
//   rsp_bus carries one code point, or an error kind and unit position, per
//   transfer; result_last marks the last result of a string and every error.
//   csr_bus writes register 0 (surrogate_decode) or 1 (byte_source); write
//   only while no unit is in flight.
//   A unit passes the input register, then the result register, before its
//   result is valid on rsp_bus. Throughput: one unit per cycle while rsp_bus
//   is ready, set by the single decode step between the two registers.
//   A held high surrogate and units dropped after an error give no result.
//   Reset: both registers empty, string state cleared, surrogate_decode = 1,
//   byte_source = 0; no channel is ready while reset is high.
//   Stall: when rsp_bus.ready is low the result register holds; the input
//   register then fills and req_bus.ready drops until the result moves.
// ----------------------------------------------------------------------------
module utf16_to_utf32_decoder_core #(
   parameter int unsigned POSITION_WIDTH = u16dec_pkg::POSITION_WIDTH_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   u16dec_req_if.sink   req_bus,
   u16dec_rsp_if.source rsp_bus,
   u16dec_csr_if.sink   csr_bus
);
   import u16dec_pkg::*;

   logic                      in_valid_ff;
   logic [UNIT_WIDTH-1:0]     in_unit_ff;
   logic                      in_last_ff;
   logic                      accept;
   logic                      step;
   logic                      produce;
   logic                      out_free;
   cfg_type                   cfg;
   result_type                result;
   logic [POSITION_WIDTH-1:0] error_position;

   assign step          = in_valid_ff && (!produce || out_free);
   assign req_bus.ready = !reset && (!in_valid_ff || step);
   assign accept        = req_bus.valid && req_bus.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (accept) begin
         in_valid_ff <= 1'b1;
      end else if (step) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_unit_ff <= req_bus.code_unit;
         in_last_ff <= req_bus.unit_last;
      end
   end

   u16dec_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .csr_bus (csr_bus),
      .cfg     (cfg)
   );

   u16dec_decode #(
      .POSITION_WIDTH (POSITION_WIDTH)
   ) u_decode (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg),
      .code_unit      (in_unit_ff),
      .unit_last      (in_last_ff),
      .step           (step),
      .produce        (produce),
      .result         (result),
      .error_position (error_position)
   );

   u16dec_out_reg #(
      .POSITION_WIDTH (POSITION_WIDTH)
   ) u_out_reg (
      .clock          (clock),
      .reset          (reset),
      .load           (step && produce),
      .result         (result),
      .error_position (error_position),
      .out_free       (out_free),
      .rsp_bus        (rsp_bus)
   );
endmodule
